// File: sv/pce_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Path curvature estimator package
// Shared types, status codes and sizes of the curvature datapath.
// ============================================================================
package pce_pkg;

    localparam int MAX_PATH_POINTS_DEF = 65536;

    // Width of the shared adder and of the accumulator / remainder register.
    localparam int ACC_W  = 132;
    // Width of differences and second differences.
    localparam int DIFF_W = 35;
    localparam int N_W    = 68;
    localparam int S_W    = 66;
    localparam int ROOT_W = 65;
    localparam int D_W    = 131;
    localparam int MPL_W  = 65;
    localparam int CNT_W  = 7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_SHORT = 2'd3;

    localparam logic [2:0] P_DDY_DX = 3'd0;
    localparam logic [2:0] P_DDX_DY = 3'd1;
    localparam logic [2:0] P_DX_DX  = 3'd2;
    localparam logic [2:0] P_DY_DY  = 3'd3;
    localparam logic [2:0] P_S_R    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PEND,
        S_SHORT_A,
        S_SHORT_B,
        S_DIFF,
        S_MLOAD,
        S_MRUN,
        S_CHKS,
        S_SQRT,
        S_SAT,
        S_DIV,
        S_FIN,
        S_RES,
        S_END
    } t_state;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] neg;
        neg = -v;
        return v[DIFF_W-1] ? neg : v;
    endfunction

endpackage

// File: sv/path_curvature_estimator.sv
`timescale 1ns / 1ps
// ============================================================================
// Path curvature estimator
// Three-point finite-difference curvature of a waypoint stream, Q8.24 out.
// ============================================================================
//
//  Channel   Direction  tdata (low bit up)                 tuser    tlast
//  s         in         x_pos[31:0], y_pos[31:0]           -        last_point
//  m         out        curvature[31:0], point_index[15:0] status   end_of_path
//
//  A curvature runs serially on one 132-bit adder: four serial products of the
//  differences, a 65-step square root, a serial product of S and the root and a
//  32-step division. A zero step ends after the products and a saturated one
//  skips the division. The third point of a path needs two curvatures; points 0
//  and 1 are only stored, and a short path gives one result per point. The input
//  is ready only while the sequencer is idle; a stalled output holds it at the
//  state that pushes a result. Reset drops a held end result.
//
module path_curvature_estimator #(
    parameter int MAX_PATH_POINTS = pce_pkg::MAX_PATH_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // x_pos[31:0], y_pos[63:32]
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // curvature[31:0], point_index[47:32]
    output logic [1:0]  o_m_tuser,   // status[1:0]
    output logic        o_m_tlast
);
    import pce_pkg::*;

    localparam int IDX_W = $clog2(MAX_PATH_POINTS);

    t_state r_state, n_state;

    logic [31:0] r_wx [3];
    logic [31:0] r_wy [3];
    logic [IDX_W-1:0] r_ps, n_ps;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic r_last, n_last;
    logic r_first, n_first;
    logic r_pend_v, n_pend_v;
    logic [31:0] r_pend_curv, n_pend_curv;
    logic [1:0] r_pend_st, n_pend_st;

    logic [DIFF_W-1:0] r_dx, r_dy, r_ddx, r_ddy, n_dx, n_dy, n_ddx, n_ddy;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [ACC_W-1:0] r_mcand, n_mcand;
    logic [MPL_W-1:0] r_mplier, n_mplier;
    logic r_msub, n_msub;
    logic [2:0] r_pidx, n_pidx;
    logic [N_W-2:0] r_nmag, n_nmag;
    logic r_neg, n_neg;
    logic [S_W-1:0] r_s, n_s;
    logic [S_W-1:0] r_xsh, n_xsh;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [D_W-1:0] r_d, n_d;
    logic [31:0] r_q, n_q;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0] r_curv, n_curv;
    logic [1:0] r_st, n_st;

    logic r_ovalid;
    logic [31:0] r_ocurv;
    logic [15:0] r_oidx;
    logic [1:0] r_ost;
    logic r_oend;

    // Shared adder / subtractor.
    logic [ACC_W-1:0] opa, opb;
    logic sub;
    logic [ACC_W:0] sum;
    logic carry;

    assign sum   = {1'b0, opa} + {1'b0, opb ^ {ACC_W{sub}}} + (ACC_W+1)'(sub);
    assign carry = sum[ACC_W];

    logic s_acc;
    logic in_last;
    logic out_free;
    logic push;
    logic [31:0] push_curv;
    logic [15:0] push_idx;
    logic [1:0] push_st;
    logic push_end;

    logic [DIFF_W-1:0] w0x, w1x, w2x, w0y, w1y, w2y;
    logic [N_W-1:0] nneg;
    logic [31:0] qneg;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign in_last    = i_s_tlast || (r_ps == IDX_W'(MAX_PATH_POINTS - 1));
    assign out_free   = !r_ovalid || i_m_tready;

    assign w0x = DIFF_W'($signed(r_wx[0]));
    assign w1x = DIFF_W'($signed(r_wx[1]));
    assign w2x = DIFF_W'($signed(r_wx[2]));
    assign w0y = DIFF_W'($signed(r_wy[0]));
    assign w1y = DIFF_W'($signed(r_wy[1]));
    assign w2y = DIFF_W'($signed(r_wy[2]));
    assign nneg = -r_acc[N_W-1:0];
    assign qneg = -r_q;

    always_comb begin
        n_state     = r_state;
        n_ps        = r_ps;
        n_idx       = r_idx;
        n_last      = r_last;
        n_first     = r_first;
        n_pend_v    = r_pend_v;
        n_pend_curv = r_pend_curv;
        n_pend_st   = r_pend_st;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_ddx       = r_ddx;
        n_ddy       = r_ddy;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_msub      = r_msub;
        n_pidx      = r_pidx;
        n_nmag      = r_nmag;
        n_neg       = r_neg;
        n_s         = r_s;
        n_xsh       = r_xsh;
        n_root      = r_root;
        n_d         = r_d;
        n_q         = r_q;
        n_cnt       = r_cnt;
        n_curv      = r_curv;
        n_st        = r_st;
        opa         = r_acc;
        opb         = r_mcand;
        sub         = r_msub;
        push        = 1'b0;
        push_curv   = '0;
        push_idx    = '0;
        push_st     = ST_SHORT;
        push_end    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_idx   = r_ps;
                    n_last  = in_last;
                    n_first = (r_ps == IDX_W'(2));
                    n_ps    = in_last ? '0 : r_ps + 1'b1;
                    if (r_pend_v) begin
                        n_state = S_PEND;
                    end else if (r_ps == '0 || r_ps == IDX_W'(1)) begin
                        n_state = in_last ? S_SHORT_A : S_IDLE;
                    end else begin
                        n_state = S_DIFF;
                    end
                end
            end
            S_PEND: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_curv = r_pend_curv;
                    push_idx  = 16'd2;
                    push_st   = r_pend_st;
                    push_end  = 1'b1;
                    n_pend_v  = 1'b0;
                    if (r_idx == '0 || r_idx == IDX_W'(1)) begin
                        n_state = r_last ? S_SHORT_A : S_IDLE;
                    end else begin
                        n_state = S_DIFF;
                    end
                end
            end
            S_SHORT_A: begin
                if (out_free) begin
                    push     = 1'b1;
                    push_end = (r_idx == '0);
                    n_state  = (r_idx == '0) ? S_IDLE : S_SHORT_B;
                end
            end
            S_SHORT_B: begin
                if (out_free) begin
                    push     = 1'b1;
                    push_idx = 16'd1;
                    push_end = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_DIFF: begin
                // The first point of a path uses the forward difference p1 - p0.
                n_dx    = r_first ? w1x - w0x : w2x - w1x;
                n_dy    = r_first ? w1y - w0y : w2y - w1y;
                n_ddx   = w2x + w0x - (w1x << 1);
                n_ddy   = w2y + w0y - (w1y << 1);
                n_pidx  = P_DDY_DX;
                n_state = S_MLOAD;
            end
            S_MLOAD: begin
                n_state = S_MRUN;
                unique case (r_pidx)
                    P_DDY_DX: begin
                        n_acc    = '0;
                        n_mcand  = ACC_W'(abs_diff(r_ddy));
                        n_mplier = MPL_W'(abs_diff(r_dx));
                        n_msub   = r_ddy[DIFF_W-1] ^ r_dx[DIFF_W-1];
                    end
                    P_DDX_DY: begin
                        n_mcand  = ACC_W'(abs_diff(r_ddx));
                        n_mplier = MPL_W'(abs_diff(r_dy));
                        n_msub   = !(r_ddx[DIFF_W-1] ^ r_dy[DIFF_W-1]);
                    end
                    P_DX_DX: begin
                        n_neg    = r_acc[N_W-1];
                        n_nmag   = r_acc[N_W-1] ? nneg[N_W-2:0] : r_acc[N_W-2:0];
                        n_acc    = '0;
                        n_mcand  = ACC_W'(abs_diff(r_dx));
                        n_mplier = MPL_W'(abs_diff(r_dx));
                        n_msub   = 1'b0;
                    end
                    P_DY_DY: begin
                        n_mcand  = ACC_W'(abs_diff(r_dy));
                        n_mplier = MPL_W'(abs_diff(r_dy));
                        n_msub   = 1'b0;
                    end
                    default: begin
                        n_acc    = '0;
                        n_mcand  = ACC_W'(r_s);
                        n_mplier = r_root;
                        n_msub   = 1'b0;
                    end
                endcase
            end
            S_MRUN: begin
                if (r_mplier == '0) begin
                    n_pidx = r_pidx + 1'b1;
                    if (r_pidx == P_DY_DY) begin
                        n_state = S_CHKS;
                    end else if (r_pidx == P_S_R) begin
                        n_d     = r_acc[D_W-1:0];
                        n_state = S_SAT;
                    end else begin
                        n_state = S_MLOAD;
                    end
                end else begin
                    if (r_mplier[0]) begin
                        n_acc = sum[ACC_W-1:0];
                    end
                    n_mcand  = r_mcand << 1;
                    n_mplier = r_mplier >> 1;
                end
            end
            S_CHKS: begin
                if (r_acc[S_W-1:0] == '0) begin
                    n_curv  = '0;
                    n_st    = ST_ZERO;
                    n_state = S_RES;
                end else begin
                    n_s     = r_acc[S_W-1:0];
                    n_xsh   = r_acc[S_W-1:0];
                    n_acc   = '0;
                    n_root  = '0;
                    n_cnt   = CNT_W'(ROOT_W - 1);
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                // Restoring root of S * 2^64; the low 64 bits come in as zeros.
                opa   = {r_acc[ACC_W-3:0], r_xsh[S_W-1:S_W-2]};
                opb   = ACC_W'({r_root, 2'b01});
                sub   = 1'b1;
                n_acc = carry ? sum[ACC_W-1:0] : opa;
                n_root = {r_root[ROOT_W-2:0], carry};
                n_xsh = r_xsh << 2;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_pidx  = P_S_R;
                    n_state = S_MLOAD;
                end
            end
            S_SAT: begin
                opa = ACC_W'({r_nmag, 40'd0});
                opb = ACC_W'(r_d);
                sub = 1'b1;
                if (carry) begin
                    n_curv  = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    n_st    = ST_SAT;
                    n_state = S_RES;
                end else begin
                    n_acc   = opa;
                    n_q     = '0;
                    n_cnt   = CNT_W'(31);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                opa   = {r_acc[ACC_W-2:0], 1'b0};
                opb   = ACC_W'(r_d);
                sub   = 1'b1;
                n_acc = carry ? sum[ACC_W-1:0] : opa;
                n_q   = {r_q[30:0], carry};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_RES;
                if (!r_neg && r_q[31]) begin
                    n_curv = 32'h7FFF_FFFF;
                    n_st   = ST_SAT;
                end else if (r_neg && r_q > 32'h8000_0000) begin
                    n_curv = 32'h8000_0000;
                    n_st   = ST_SAT;
                end else begin
                    n_curv = r_neg ? qneg : r_q;
                    n_st   = ST_OK;
                end
            end
            S_RES: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_curv = r_curv;
                    push_idx  = r_first ? 16'd0 : 16'(r_idx - 1'b1);
                    push_st   = r_st;
                    if (r_first) begin
                        n_first = 1'b0;
                        n_state = S_DIFF;
                    end else if (r_last && r_idx == IDX_W'(2)) begin
                        // A three-point path gives its end result with the next item.
                        n_pend_v    = 1'b1;
                        n_pend_curv = r_curv;
                        n_pend_st   = r_st;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = r_last ? S_END : S_IDLE;
                    end
                end
            end
            S_END: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_curv = r_curv;
                    push_idx  = 16'(r_idx);
                    push_st   = r_st;
                    push_end  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ps     <= '0;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
            r_wx     <= '{default: '0};
            r_wy     <= '{default: '0};
        end else begin
            r_state  <= n_state;
            r_ps     <= n_ps;
            r_pend_v <= n_pend_v;
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (s_acc) begin
                r_wx[0] <= r_wx[1];
                r_wx[1] <= r_wx[2];
                r_wx[2] <= i_s_tdata[31:0];
                r_wy[0] <= r_wy[1];
                r_wy[1] <= r_wy[2];
                r_wy[2] <= i_s_tdata[63:32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_last      <= n_last;
        r_first     <= n_first;
        r_pend_curv <= n_pend_curv;
        r_pend_st   <= n_pend_st;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_ddx       <= n_ddx;
        r_ddy       <= n_ddy;
        r_acc       <= n_acc;
        r_mcand     <= n_mcand;
        r_mplier    <= n_mplier;
        r_msub      <= n_msub;
        r_pidx      <= n_pidx;
        r_nmag      <= n_nmag;
        r_neg       <= n_neg;
        r_s         <= n_s;
        r_xsh       <= n_xsh;
        r_root      <= n_root;
        r_d         <= n_d;
        r_q         <= n_q;
        r_cnt       <= n_cnt;
        r_curv      <= n_curv;
        r_st        <= n_st;
        if (push) begin
            r_ocurv <= push_curv;
            r_oidx  <= push_idx;
            r_ost   <= push_st;
            r_oend  <= push_end;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_oidx, r_ocurv};
    assign o_m_tuser  = r_ost;
    assign o_m_tlast  = r_oend;

    // The division remainder always stays below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_acc < {1'b0, r_d}))
        else $error("division remainder not below divisor");

    // A held end result only exists between paths.
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_pend_v) |-> (r_ps == '0))
        else $error("held end result inside a path");

    // Short-path and zero-step results carry zero curvature.
    a_zero_curv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ST_SHORT || o_m_tuser == ST_ZERO))
            |-> (o_m_tdata[31:0] == 32'd0))
        else $error("nonzero curvature with short or zero-step status");

endmodule
